// ===== hw/rtl/stt_pkg.sv =====
// Shared types and constants for the software timer table.
// Used by stt_ctrl, stt_dp and software_timer_table; depends on nothing.
`default_nettype none

package stt_pkg;

  // Most tick results reported for one tick item
  localparam int MaxResults = 8;

  typedef enum logic [2:0] {
    MODE_CREATE    = 3'd0,
    MODE_START     = 3'd1,
    MODE_STOP      = 3'd2,
    MODE_DELETE    = 3'd3,
    MODE_TICK      = 3'd4,
    MODE_REMAINING = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_BAD_INDEX   = 2'd1,
    STATUS_INACTIVE    = 2'd2,
    STATUS_CREATE_FAIL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic scan;
    logic flush;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic is_tick;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stt_ctrl.sv =====
// Controller state machine for the software timer table.
// Depends on stt_pkg; drives the command bundle of stt_dp.
`default_nettype none

module stt_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [2:0]         mode_i,
  input  wire stt_pkg::dp_status_t dp_status_i,
  output stt_pkg::cmd_t           cmd_o,
  output logic                    busy_o
);

  stt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = (state_q != stt_pkg::ST_IDLE);
    unique case (state_q)
      stt_pkg::ST_IDLE: begin
        if (start_i) begin
          unique case (stt_pkg::mode_e'(mode_i))
            stt_pkg::MODE_CREATE,
            stt_pkg::MODE_TICK: begin
              cmd_o.load = 1'b1;
              state_d    = stt_pkg::ST_SCAN;
            end
            stt_pkg::MODE_START,
            stt_pkg::MODE_STOP,
            stt_pkg::MODE_DELETE,
            stt_pkg::MODE_REMAINING: begin
              cmd_o.load = 1'b1;
              state_d    = stt_pkg::ST_EXEC;
            end
            // unused modes: drop the item
            default: state_d = stt_pkg::ST_IDLE;
          endcase
        end
      end
      stt_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stt_pkg::ST_IDLE;
      end
      stt_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (dp_status_i.scan_done) begin
          state_d = dp_status_i.is_tick ? stt_pkg::ST_FLUSH : stt_pkg::ST_IDLE;
        end
      end
      stt_pkg::ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = stt_pkg::ST_IDLE;
      end
      default: state_d = stt_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stt_dp.sv =====
// Datapath of the software timer table: latched item, slot table, scan
// pointer, pending tick result and result registers. Depends on stt_pkg.
`default_nettype none

module stt_dp #(
  parameter int NUM_TIMERS = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire stt_pkg::cmd_t       cmd_i,
  output stt_pkg::dp_status_t      dp_status_o,
  input  wire logic [2:0]          mode_i,
  input  wire logic [3:0]          slot_index_i,
  input  wire logic [31:0]         period_in_i,
  input  wire logic                repeat_in_i,
  input  wire logic [31:0]         now_ms_i,
  output logic                     result_valid_o,
  output logic [1:0]               status_o,
  output logic [3:0]               slot_out_o,
  output logic [31:0]              time_left_o,
  output logic                     fired_o,
  output logic                     last_o
);

  localparam int IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CntW = $clog2(stt_pkg::MaxResults + 1);

  // Latched item
  logic [2:0]  mode_q;
  logic [3:0]  idx_q;
  logic [31:0] period_q;
  logic        repeat_q;
  logic [31:0] now_q;

  // Scan control
  logic [IdxW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pend_vld_q, pend_vld_d;
  logic [IdxW-1:0] pend_slot_q, pend_slot_d;

  // Slot table
  logic [NUM_TIMERS-1:0] active_q;
  logic [NUM_TIMERS-1:0] repeat_arr_q;
  logic [31:0]           period_arr_q   [NUM_TIMERS];
  logic [31:0]           deadline_arr_q [NUM_TIMERS];

  // Result registers
  logic        rvalid_q, rvalid_d;
  logic [1:0]  status_q, status_d;
  logic [3:0]  slot_q, slot_d;
  logic [31:0] left_q, left_d;
  logic        fired_q, fired_d;
  logic        last_q, last_d;

  // Table write controls
  logic        act_we, act_wd, cfg_we, dl_we;
  logic [31:0] dl_wd;

  logic [IdxW-1:0] sel;
  logic            sel_act, sel_rep;
  logic [31:0]     sel_per, sel_dl, sum;
  logic            idx_ok, is_due, ptr_last, cnt_full, scan_done;

  assign sel      = cmd_i.exec ? idx_q[IdxW-1:0] : ptr_q;
  assign sel_act  = active_q[sel];
  assign sel_rep  = repeat_arr_q[sel];
  assign sel_per  = period_arr_q[sel];
  assign sel_dl   = deadline_arr_q[sel];
  assign sum      = now_q + sel_per;
  assign idx_ok   = ({1'b0, idx_q} < 5'(NUM_TIMERS));
  assign is_due   = sel_act && (sel_dl != 32'd0) && (now_q >= sel_dl);
  assign ptr_last = (ptr_q == IdxW'(NUM_TIMERS - 1));
  assign cnt_full = (cnt_q == CntW'(stt_pkg::MaxResults));

  assign dp_status_o.scan_done = scan_done;
  assign dp_status_o.is_tick   = (mode_q == stt_pkg::MODE_TICK);

  always_comb begin
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    pend_vld_d  = pend_vld_q;
    pend_slot_d = pend_slot_q;
    rvalid_d    = 1'b0;
    status_d    = stt_pkg::STATUS_OK;
    slot_d      = 4'd0;
    left_d      = 32'd0;
    fired_d     = 1'b0;
    last_d      = 1'b1;
    act_we      = 1'b0;
    act_wd      = 1'b0;
    cfg_we      = 1'b0;
    dl_we       = 1'b0;
    dl_wd       = 32'd0;
    scan_done   = 1'b0;

    if (cmd_i.load) begin
      ptr_d      = '0;
      cnt_d      = '0;
      pend_vld_d = 1'b0;
    end

    if (cmd_i.exec) begin
      rvalid_d = 1'b1;
      unique case (stt_pkg::mode_e'(mode_q))
        stt_pkg::MODE_START,
        stt_pkg::MODE_STOP: begin
          if (!idx_ok) begin
            status_d = stt_pkg::STATUS_BAD_INDEX;
          end else if (!sel_act) begin
            status_d = stt_pkg::STATUS_INACTIVE;
          end else begin
            dl_we = 1'b1;
            dl_wd = (mode_q == stt_pkg::MODE_START) ? sum : 32'd0;
          end
        end
        stt_pkg::MODE_DELETE: begin
          if (!idx_ok) begin
            status_d = stt_pkg::STATUS_BAD_INDEX;
          end else begin
            act_we = 1'b1;
            act_wd = 1'b0;
          end
        end
        stt_pkg::MODE_REMAINING: begin
          if (!idx_ok) begin
            status_d = stt_pkg::STATUS_BAD_INDEX;
          end else if (!sel_act) begin
            status_d = stt_pkg::STATUS_INACTIVE;
          end else if (sel_dl != 32'd0 && now_q < sel_dl) begin
            left_d = sel_dl - now_q;
          end
        end
        default: rvalid_d = 1'b0;
      endcase
    end

    if (cmd_i.scan) begin
      ptr_d = ptr_q + IdxW'(1);
      if (mode_q == stt_pkg::MODE_TICK) begin
        scan_done = ptr_last;
        if (is_due && !cnt_full) begin
          dl_we       = 1'b1;
          dl_wd       = sel_rep ? sum : 32'd0;
          cnt_d       = cnt_q + CntW'(1);
          pend_vld_d  = 1'b1;
          pend_slot_d = ptr_q;
          // the earlier due slot now has a successor: send it as non-final
          if (pend_vld_q) begin
            rvalid_d = 1'b1;
            slot_d   = 4'(pend_slot_q);
            fired_d  = 1'b1;
            last_d   = 1'b0;
          end
        end
      end else begin
        if (period_q == 32'd0) begin
          scan_done = 1'b1;
          rvalid_d  = 1'b1;
          status_d  = stt_pkg::STATUS_CREATE_FAIL;
        end else if (!sel_act) begin
          scan_done = 1'b1;
          rvalid_d  = 1'b1;
          slot_d    = 4'(ptr_q);
          act_we    = 1'b1;
          act_wd    = 1'b1;
          cfg_we    = 1'b1;
          dl_we     = 1'b1;
          dl_wd     = 32'd0;
        end else if (ptr_last) begin
          scan_done = 1'b1;
          rvalid_d  = 1'b1;
          status_d  = stt_pkg::STATUS_CREATE_FAIL;
        end
      end
    end

    if (cmd_i.flush) begin
      rvalid_d = 1'b1;
      if (pend_vld_q) begin
        slot_d  = 4'(pend_slot_q);
        fired_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q     <= 1'b0;
      active_q     <= '0;
      repeat_arr_q <= '0;
      pend_vld_q   <= 1'b0;
    end else begin
      rvalid_q   <= rvalid_d;
      pend_vld_q <= pend_vld_d;
      if (act_we) begin
        active_q[sel] <= act_wd;
      end
      if (cfg_we) begin
        repeat_arr_q[sel] <= repeat_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q   <= mode_i;
      idx_q    <= slot_index_i;
      period_q <= period_in_i;
      repeat_q <= repeat_in_i;
      now_q    <= now_ms_i;
    end
    ptr_q       <= ptr_d;
    cnt_q       <= cnt_d;
    pend_slot_q <= pend_slot_d;
    status_q    <= status_d;
    slot_q      <= slot_d;
    left_q      <= left_d;
    fired_q     <= fired_d;
    last_q      <= last_d;
    if (cfg_we) begin
      period_arr_q[sel] <= period_q;
    end
    if (dl_we) begin
      deadline_arr_q[sel] <= dl_wd;
    end
  end

  assign result_valid_o = rvalid_q;
  assign status_o       = status_q;
  assign slot_out_o     = slot_q;
  assign time_left_o    = left_q;
  assign fired_o        = fired_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/software_timer_table.sv =====
// Top level of the software timer table: controller plus datapath.
// Depends on stt_pkg, stt_ctrl and stt_dp.
//
// An item is taken when start_i is high while busy_o is low. Each result is
// shown for one cycle with result_valid_o and cannot be held off; last_o
// marks the final result of an item. Start, stop, delete and remaining keep
// busy_o high through the exec state, from which their result is registered.
// Create scans the slot table one slot per cycle until it meets a free slot
// or the last slot (it stops at once for a zero period), and tick always
// scans all NUM_TIMERS slots and then closes in the flush state; the rate is
// set by this scan through the single read port of the slot table. A tick
// reports up to eight due slots, each on its own cycle, and all slots are
// stopped and free after reset. Items with an unused mode code are dropped without a result.
`default_nettype none

module software_timer_table #(
  parameter int NUM_TIMERS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  mode_i,
  input  wire logic [3:0]  slot_index_i,
  input  wire logic [31:0] period_in_i,
  input  wire logic        repeat_in_i,
  input  wire logic [31:0] now_ms_i,
  output logic             result_valid_o,
  output logic [1:0]       status_o,
  output logic [3:0]       slot_out_o,
  output logic [31:0]      time_left_o,
  output logic             fired_o,
  output logic             last_o
);

  stt_pkg::cmd_t       cmd;
  stt_pkg::dp_status_t dp_status;

  stt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .mode_i      (mode_i),
    .dp_status_i (dp_status),
    .cmd_o       (cmd),
    .busy_o      (busy_o)
  );

  stt_dp #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .dp_status_o    (dp_status),
    .mode_i         (mode_i),
    .slot_index_i   (slot_index_i),
    .period_in_i    (period_in_i),
    .repeat_in_i    (repeat_in_i),
    .now_ms_i       (now_ms_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .slot_out_o     (slot_out_o),
    .time_left_o    (time_left_o),
    .fired_o        (fired_o),
    .last_o         (last_o)
  );

`ifndef NO_ASSERTIONS
  // A fired tick result always carries status ok
  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && fired_o |-> status_o == stt_pkg::STATUS_OK)
    else $error("fired result with non-ok status");

  // Only tick produces non-final results, and those report a fired slot
  a_nonlast_fired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> fired_o)
    else $error("non-final result without fired slot");

  // Start, stop, delete and remaining answer with a final result from the exec state
  a_single_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (mode_i == stt_pkg::MODE_START || mode_i == stt_pkg::MODE_STOP
      || mode_i == stt_pkg::MODE_DELETE || mode_i == stt_pkg::MODE_REMAINING)
    |-> ##2 result_valid_o && last_o)
    else $error("single-result item missed its result slot");
`endif

endmodule

`default_nettype wire
